// ----- hdl/etadp_pkg.sv -----
// Shared types and constants for the energy threshold adapter.
// Used by etadp_div, etadp_mul and energy_threshold_adapter; no dependencies.
package etadp_pkg;

  localparam int DW    = 32;
  localparam int CNT_W = 6;

  localparam logic [1:0] ACT_BEGIN   = 2'd0;
  localparam logic [1:0] ACT_CHARGED = 2'd1;
  localparam logic [1:0] ACT_END     = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam logic [2:0] REG_MAX_INDEX     = 3'd0;
  localparam logic [2:0] REG_CODE_STEP     = 3'd1;
  localparam logic [2:0] REG_MIN_CHARGE    = 3'd2;
  localparam logic [2:0] REG_MAX_DROP      = 3'd3;
  localparam logic [2:0] REG_INITIAL_INDEX = 3'd4;

  localparam logic [7:0]  RST_MAX_INDEX     = 8'd31;
  localparam logic [11:0] RST_CODE_STEP     = 12'd64;
  localparam logic [15:0] RST_MIN_CHARGE    = 16'd0;
  localparam logic [12:0] RST_MAX_DROP      = 13'd4096;
  localparam logic [7:0]  RST_INITIAL_INDEX = 8'd16;

  localparam logic [8:0] RAISE_STEP = 9'd2;

  typedef struct packed {
    logic start;
  } op_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } op_stat_t;

  function automatic logic [7:0] raise_index(input logic [7:0] cur, input logic [7:0] lim);
    logic [8:0] v;
    v = {1'b0, cur} + RAISE_STEP;
    raise_index = (v > {1'b0, lim}) ? lim : v[7:0];
  endfunction

endpackage

// ----- hdl/energy_threshold_adapter.sv -----
// Energy threshold adapter top level: config registers, task state, drop ring
// and the event sequencer. Depends on etadp_pkg, etadp_div, etadp_mul.
// Begin, charged and non-profiled end events go straight to the result; a profiled
// end runs the divider and then the multiplier, followed by a ring read and two more
// divider passes when the ring fills. One word in flight; the next is taken once a
// result sits in the output.
// Reset (rst, synchronous): thresholds to 16, flags, positions and config to defaults;
// the drop ring is not cleared.
module energy_threshold_adapter #(
  parameter int TASKS         = 8,
  parameter int HISTORY_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func_id[2:0], comparator_high[3], vcc_first[15:4], vcc_second[27:16],
  // timer_ticks[43:28], zero[47:44]
  input  logic [47:0] s_axis_tdata,
  // action[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // threshold_index[7:0], profiling[8], drop_value[24:9], drop_accepted[25],
  // zero[31:26]
  output logic [31:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NT    = (TASKS < 8) ? TASKS : 8;
  localparam int TW    = (NT > 1) ? $clog2(NT) : 1;
  localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW    = $clog2(HISTORY_DEPTH + 1);
  localparam int SW    = 12 + $clog2(HISTORY_DEPTH);
  localparam int MEM_D = 2 ** (TW + PW);
  localparam logic [6:0]    TASKS_C = 7'(TASKS);
  localparam logic [PW:0]   HD_P    = (PW + 1)'(HISTORY_DEPTH);
  localparam logic [CW-1:0] HD_C    = CW'(HISTORY_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_DIVQ, S_MUL, S_HRD, S_DIVM, S_DIVS, S_DONE
  } state_t;

  state_t state;

  logic [7:0]  max_index;
  logic [11:0] code_step;
  logic [15:0] min_charge_ticks;
  logic [12:0] max_drop;
  logic [7:0]  initial_index;

  logic [7:0]    thr [NT];
  logic          failed [NT];
  logic [PW-1:0] pos [NT];

  logic        prof;
  logic [11:0] cend;
  logic [15:0] ctime;
  logic [31:0] cdelta;

  logic [TW-1:0] t_r;
  logic [11:0]   v2_r;
  logic [15:0]   ticks_r;
  logic [15:0]   drop_r;
  logic          acc_r;

  logic [CW-1:0] rd_cnt;
  logic          rd_v;
  logic [SW-1:0] sum;

  logic [11:0] drop_mem [MEM_D];
  logic [11:0] rdata;

  etadp_pkg::op_ctl_t  div_ctl;
  etadp_pkg::op_ctl_t  mul_ctl;
  etadp_pkg::op_stat_t div_st;
  etadp_pkg::op_stat_t mul_st;
  logic [31:0] div_a;
  logic [31:0] div_b;
  logic [31:0] div_q;
  logic [31:0] mul_a;
  logic [31:0] mul_init;
  logic [31:0] mul_p;

  logic [1:0]    act_in;
  logic [2:0]    fid_mod;
  logic [TW-1:0] t_in;
  logic          comp_in;
  logic [11:0]   v1_in;
  logic [11:0]   v2_in;
  logic [15:0]   ticks_in;
  logic [15:0]   drop_c;
  logic          drop_ok;
  logic          pos_wrap;
  logic          rd_en;
  logic          wr_en;
  logic          out_load;
  logic [7:0]    idx_c;
  logic [11:0]   step_c;
  logic          cfg_wr;
  logic          div_go;
  logic          mul_go;

  assign act_in   = s_axis_tuser;
  assign comp_in  = s_axis_tdata[3];
  assign v1_in    = s_axis_tdata[15:4];
  assign v2_in    = s_axis_tdata[27:16];
  assign ticks_in = s_axis_tdata[43:28];

  always_comb begin
    fid_mod = s_axis_tdata[2:0];
    for (int i = 0; i < 8; i++) begin
      if ({4'd0, fid_mod} >= TASKS_C) begin
        fid_mod = fid_mod - TASKS_C[2:0];
      end
    end
  end
  assign t_in = fid_mod[TW-1:0];

  assign s_axis_tready = (state == S_IDLE);
  assign pready        = 1'b1;
  assign cfg_wr        = psel && penable && pwrite && pready;

  assign drop_c   = mul_p[23:8];
  assign drop_ok  = drop_c < {3'd0, max_drop};
  assign pos_wrap = ({1'b0, pos[t_r]} + 1'b1) >= HD_P;
  assign rd_en    = (state == S_HRD) && (rd_cnt < HD_C);
  assign wr_en    = (state == S_MUL) && mul_st.done && drop_ok;
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);
  assign idx_c    = (div_q[7:0] > max_index) ? max_index : div_q[7:0];
  assign step_c   = (code_step == 12'd0) ? 12'd1 : code_step;

  assign div_go = ((state == S_IDLE) && s_axis_tvalid && (act_in == etadp_pkg::ACT_END) &&
                   comp_in && prof) ||
                  ((state == S_HRD) && !rd_en && !rd_v) ||
                  ((state == S_DIVM) && div_st.done);
  assign mul_go = (state == S_DIVQ) && div_st.done;

  etadp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_st),
    .quotient (div_q)
  );

  etadp_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mul_ctl),
    .mplier (mul_a),
    .mcand  (cdelta),
    .addend (mul_init),
    .stat   (mul_st),
    .acc    (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_index        <= etadp_pkg::RST_MAX_INDEX;
      code_step        <= etadp_pkg::RST_CODE_STEP;
      min_charge_ticks <= etadp_pkg::RST_MIN_CHARGE;
      max_drop         <= etadp_pkg::RST_MAX_DROP;
      initial_index    <= etadp_pkg::RST_INITIAL_INDEX;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        etadp_pkg::REG_MAX_INDEX:     max_index        <= pwdata[7:0];
        etadp_pkg::REG_CODE_STEP:     code_step        <= pwdata[11:0];
        etadp_pkg::REG_MIN_CHARGE:    min_charge_ticks <= pwdata[15:0];
        etadp_pkg::REG_MAX_DROP:      max_drop         <= pwdata[12:0];
        etadp_pkg::REG_INITIAL_INDEX: initial_index    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      etadp_pkg::REG_MAX_INDEX:     prdata = {24'd0, max_index};
      etadp_pkg::REG_CODE_STEP:     prdata = {20'd0, code_step};
      etadp_pkg::REG_MIN_CHARGE:    prdata = {16'd0, min_charge_ticks};
      etadp_pkg::REG_MAX_DROP:      prdata = {19'd0, max_drop};
      etadp_pkg::REG_INITIAL_INDEX: prdata = {24'd0, initial_index};
      default:                      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      drop_mem[{t_r, pos[t_r]}] <= mul_p[19:8];
    end
    rdata <= drop_mem[{t_r, rd_cnt[PW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      div_ctl       <= '0;
      mul_ctl       <= '0;
      prof          <= 1'b0;
      cend          <= '0;
      ctime         <= '0;
      cdelta        <= '0;
      rd_cnt        <= '0;
      rd_v          <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        thr[i]    <= etadp_pkg::RST_INITIAL_INDEX;
        failed[i] <= 1'b0;
        pos[i]    <= '0;
      end
    end else begin
      div_ctl.start <= div_go;
      mul_ctl.start <= mul_go;
      if (m_axis_tready && !out_load) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            t_r     <= t_in;
            v2_r    <= v2_in;
            ticks_r <= ticks_in;
            drop_r  <= '0;
            acc_r   <= 1'b0;
            state   <= S_DONE;
            unique case (act_in)
              etadp_pkg::ACT_BEGIN: begin
                if (failed[t_in]) begin
                  failed[t_in] <= 1'b0;
                  thr[t_in]    <= etadp_pkg::raise_index(thr[t_in], max_index);
                end
              end
              etadp_pkg::ACT_CHARGED: begin
                if (!comp_in && (ticks_in > min_charge_ticks)) begin
                  prof   <= 1'b1;
                  ctime  <= ticks_in;
                  cend   <= v2_in;
                  cdelta <= {20'd0, v2_in} - {20'd0, v1_in};
                end else begin
                  prof <= 1'b0;
                end
                failed[t_in] <= 1'b1;
              end
              etadp_pkg::ACT_END: begin
                failed[t_in] <= 1'b0;
                if (!comp_in) begin
                  thr[t_in] <= etadp_pkg::raise_index(thr[t_in], max_index);
                  prof      <= 1'b0;
                end else if (prof) begin
                  div_a <= ({16'd0, ticks_in} - {16'd0, ctime}) << 8;
                  div_b <= {16'd0, ctime};
                  state <= S_DIVQ;
                end
              end
              default: ;
            endcase
          end
        end
        S_DIVQ: begin
          if (div_st.done) begin
            mul_a    <= div_q;
            mul_init <= ({20'd0, cend} - {20'd0, v2_r}) << 8;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_st.done) begin
            drop_r <= drop_c;
            state  <= S_DONE;
            if (drop_ok) begin
              acc_r <= 1'b1;
              if (pos_wrap) begin
                pos[t_r] <= '0;
                sum      <= '0;
                rd_cnt   <= '0;
                rd_v     <= 1'b0;
                state    <= S_HRD;
              end else begin
                pos[t_r] <= pos[t_r] + 1'b1;
              end
            end
          end
        end
        S_HRD: begin
          if (rd_en) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          rd_v <= rd_en;
          if (rd_v) begin
            sum <= sum + SW'(rdata);
          end
          if (!rd_en && !rd_v) begin
            div_a <= 32'(sum);
            div_b <= 32'(HISTORY_DEPTH);
            state <= S_DIVM;
          end
        end
        S_DIVM: begin
          if (div_st.done) begin
            div_a <= div_q;
            div_b <= {20'd0, step_c};
            state <= S_DIVS;
          end
        end
        S_DIVS: begin
          if (div_st.done) begin
            thr[t_r] <= idx_c;
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_axis_tdata  <= {6'd0, acc_r, drop_r, prof, thr[t_r]};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(div_st.busy || mul_st.busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in flight");

  a_stored_drop_in_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (drop_c < {3'd0, max_drop}))
    else $error("drop at or above limit written to ring");

  a_result_has_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_axis_tvalid)
    else $error("result load did not raise valid");

endmodule

// ----- hdl/etadp_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, 32-bit operands.
// Depends on etadp_pkg.
module etadp_div (
  input  logic                      clk,
  input  logic                      rst,
  input  etadp_pkg::op_ctl_t        ctl,
  input  logic [etadp_pkg::DW-1:0]  dividend,
  input  logic [etadp_pkg::DW-1:0]  divisor,
  output etadp_pkg::op_stat_t       stat,
  output logic [etadp_pkg::DW-1:0]  quotient
);

  logic [etadp_pkg::DW-1:0]    rem;
  logic [etadp_pkg::DW-1:0]    den;
  logic [etadp_pkg::CNT_W-1:0] cnt;
  logic [etadp_pkg::DW:0]      shifted;
  logic [etadp_pkg::DW+1:0]    diff;

  assign shifted = {rem, quotient[etadp_pkg::DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !ctl.start && stat.busy && (cnt == etadp_pkg::CNT_W'(1));
      if (ctl.start) begin
        quotient  <= dividend;
        den       <= divisor;
        rem       <= '0;
        cnt       <= etadp_pkg::CNT_W'(etadp_pkg::DW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (diff[etadp_pkg::DW+1]) begin
          rem      <= shifted[etadp_pkg::DW-1:0];
          quotient <= {quotient[etadp_pkg::DW-2:0], 1'b0};
        end else begin
          rem      <= diff[etadp_pkg::DW-1:0];
          quotient <= {quotient[etadp_pkg::DW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == etadp_pkg::CNT_W'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/etadp_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, low 32 bits kept,
// accumulating onto a preset addend. Depends on etadp_pkg.
module etadp_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  etadp_pkg::op_ctl_t        ctl,
  input  logic [etadp_pkg::DW-1:0]  mplier,
  input  logic [etadp_pkg::DW-1:0]  mcand,
  input  logic [etadp_pkg::DW-1:0]  addend,
  output etadp_pkg::op_stat_t       stat,
  output logic [etadp_pkg::DW-1:0]  acc
);

  logic [etadp_pkg::DW-1:0]    mq;
  logic [etadp_pkg::DW-1:0]    mc;
  logic [etadp_pkg::CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= !ctl.start && stat.busy && (cnt == etadp_pkg::CNT_W'(1));
      if (ctl.start) begin
        mq        <= mplier;
        mc        <= mcand;
        acc       <= addend;
        cnt       <= etadp_pkg::CNT_W'(etadp_pkg::DW);
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        if (mq[0]) begin
          acc <= acc + mc;
        end
        mq  <= {1'b0, mq[etadp_pkg::DW-1:1]};
        mc  <= {mc[etadp_pkg::DW-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == etadp_pkg::CNT_W'(1)) begin
          stat.busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- verif/tb_energy_threshold_adapter.sv -----
// Self-checking testbench for energy_threshold_adapter: directed events, register
// sweeps, backpressure and random task sequences checked against a built-in predictor.
// Depends on etadp_pkg and the energy_threshold_adapter RTL.
`timescale 1ns / 1ps

module tb_energy_threshold_adapter;

  localparam int NTASK = 8;
  localparam int RING  = 4;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic [7:0]  thr;
    logic        prof;
    logic [15:0] drop;
    logic        acc;
  } adapt_res_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  energy_threshold_adapter dut (.*);

  // predictor state
  logic [7:0]  cfg_max_index, cfg_init_index;
  logic [11:0] cfg_code_step;
  logic [15:0] cfg_min_charge;
  logic [12:0] cfg_max_drop;
  logic [7:0]  thr_q [NTASK];
  logic        failed_q [NTASK];
  logic [11:0] ring_q [NTASK][RING];
  int          ring_pos [NTASK];
  logic        prof_on;
  logic [31:0] ch_vcc, ch_time, ch_delta;

  adapt_res_t expected_q [$];
  int errors = 0, n_items = 0, n_results = 0, n_kept = 0, n_mean = 0;
  bit gaps_on = 1;
  int rx_hold = 0;

  initial forever #2 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] bump(input logic [7:0] cur);
    logic [8:0] v;
    v = {1'b0, cur} + 9'd2;
    return (v > {1'b0, cfg_max_index}) ? cfg_max_index : v[7:0];
  endfunction

  function automatic adapt_res_t predict(input logic [1:0] act, input logic [2:0] fid,
                                         input logic comp, input logic [11:0] v1,
                                         input logic [11:0] v2, input logic [15:0] ticks);
    adapt_res_t r;
    logic [31:0] run, dd, q, d, sum, idx, stp;
    r = '0;
    d = 0;
    if (act == etadp_pkg::ACT_BEGIN) begin
      if (failed_q[fid]) begin
        failed_q[fid] = 0;
        thr_q[fid] = bump(thr_q[fid]);
      end
    end else if (act == etadp_pkg::ACT_CHARGED) begin
      if (!comp && ticks > cfg_min_charge) begin
        prof_on = 1;
        ch_time = ticks;
        ch_vcc = v2;
        ch_delta = 32'(v2) - 32'(v1);
      end else begin
        prof_on = 0;
      end
      failed_q[fid] = 1;
    end else if (act == etadp_pkg::ACT_END) begin
      failed_q[fid] = 0;
      if (!comp) begin
        thr_q[fid] = bump(thr_q[fid]);
        prof_on = 0;
      end
      if (prof_on) begin
        run = 32'(ticks) - ch_time;
        dd = ch_vcc - 32'(v2);
        q = (ch_time != 0) ? (run * 32'h100) / ch_time : 32'hFFFF_FFFF;
        d = ((q * ch_delta + dd * 32'h100) >> 8) & 32'hFFFF;
        if (d < 32'(cfg_max_drop)) begin
          r.acc = 1;
          n_kept++;
          ring_q[fid][ring_pos[fid]] = d[11:0];
          ring_pos[fid]++;
          if (ring_pos[fid] >= RING) begin
            ring_pos[fid] = 0;
            sum = 0;
            for (int i = 0; i < RING; i++) sum += ring_q[fid][i];
            sum /= RING;
            stp = (cfg_code_step != 0) ? cfg_code_step : 1;
            idx = (sum / stp) & 32'hFF;
            if (idx > cfg_max_index) idx = cfg_max_index;
            thr_q[fid] = idx[7:0];
            n_mean++;
          end
        end
      end
    end
    r.thr = thr_q[fid];
    r.prof = prof_on;
    r.drop = d[15:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    adapt_res_t got, exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tdata[24:9], m_axis_tdata[25]};
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word %h", $realtime, m_axis_tdata);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.thr !== exp_r.thr) begin
          $display("%0t: threshold_index exp %0d got %0d", $realtime, exp_r.thr, got.thr);
          errors++;
        end
        if (got.prof !== exp_r.prof) begin
          $display("%0t: profiling exp %0d got %0d", $realtime, exp_r.prof, got.prof);
          errors++;
        end
        if (got.drop !== exp_r.drop) begin
          $display("%0t: drop_value exp %0d got %0d", $realtime, exp_r.drop, got.drop);
          errors++;
        end
        if (got.acc !== exp_r.acc) begin
          $display("%0t: drop_accepted exp %0d got %0d", $realtime, exp_r.acc, got.acc);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, long hold-off on request
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      m_axis_tready <= 0;
    end else if (!gaps_on) begin
      m_axis_tready <= 1;
    end else if (r < 3) begin
      m_axis_tready <= 0;
      rx_hold = $urandom_range(10, 40);
    end else begin
      m_axis_tready <= (r < 75);
    end
  end

  task automatic send_event(input logic [1:0] act, input logic [2:0] fid, input logic comp,
                            input logic [11:0] v1, input logic [11:0] v2,
                            input logic [15:0] ticks);
    int g, r;
    g = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) g = $urandom_range(10, 40);
      else if (r >= 65) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= act;
    s_axis_tdata <= {4'b0, ticks, v2, v1, comp, fid};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    expected_q.push_back(predict(act, fid, comp, v1, v2, ticks));
    n_items++;
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      etadp_pkg::REG_MAX_INDEX:     cfg_max_index = val[7:0];
      etadp_pkg::REG_CODE_STEP:     cfg_code_step = val[11:0];
      etadp_pkg::REG_MIN_CHARGE:    cfg_min_charge = val[15:0];
      etadp_pkg::REG_MAX_DROP:      cfg_max_drop = val[12:0];
      etadp_pkg::REG_INITIAL_INDEX: cfg_init_index = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] mx, input logic [11:0] stp,
                            input logic [15:0] mc, input logic [12:0] md,
                            input logic [7:0] ii);
    wait_idle();
    write_reg(etadp_pkg::REG_MAX_INDEX, mx);
    write_reg(etadp_pkg::REG_CODE_STEP, stp);
    write_reg(etadp_pkg::REG_MIN_CHARGE, mc);
    write_reg(etadp_pkg::REG_MAX_DROP, md);
    write_reg(etadp_pkg::REG_INITIAL_INDEX, ii);
  endtask

  task automatic send_noise();
    send_event(2'($urandom), 3'($urandom), 1'($urandom), 12'($urandom), 12'($urandom),
               16'($urandom));
  endtask

  // one task run: begin, charged, usually end
  task automatic task_run();
    logic [2:0]  fid;
    logic [11:0] v1, v2;
    logic [15:0] ct;
    int span;
    fid = 3'($urandom);
    send_event(etadp_pkg::ACT_BEGIN, fid, 1'($urandom), 12'($urandom), 12'($urandom),
               16'($urandom));
    span = 32'(cfg_min_charge) + 1 + $urandom_range(0, 3000);
    ct = (span > 65535) ? 16'hFFFF : 16'(span);
    v2 = 12'($urandom);
    v1 = v2 - 12'($urandom_range(0, 200));
    send_event(etadp_pkg::ACT_CHARGED, fid, $urandom_range(0, 7) == 0, v1, v2, ct);
    if ($urandom_range(0, 7) == 0) return;
    send_event(etadp_pkg::ACT_END, fid, $urandom_range(0, 9) != 0, 12'($urandom),
               v2 - 12'($urandom_range(0, 100)), 16'(32'(ct) + $urandom_range(0, 2 * ct)));
  endtask

  task automatic test_directed();
    send_event(etadp_pkg::ACT_BEGIN, 3'd7, 1, 12'd0, 12'd0, 16'd0);
    send_event(etadp_pkg::ACT_UNUSED, 3'd7, 1, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_event(etadp_pkg::ACT_END, 3'd2, 0, 12'd0, 12'd0, 16'd0);
    send_event(etadp_pkg::ACT_CHARGED, 3'd7, 0, 12'd0, 12'hFFF, 16'd0);
    send_event(etadp_pkg::ACT_BEGIN, 3'd7, 0, 12'd0, 12'd0, 16'd0);
    for (int i = 0; i < 4; i++) begin
      send_event(etadp_pkg::ACT_BEGIN, 3'd0, 1, 12'd0, 12'd0, 16'd0);
      send_event(etadp_pkg::ACT_CHARGED, 3'd0, 0, 12'd100, 12'd4000 + 12'(i), 16'd1000);
      send_event(etadp_pkg::ACT_END, 3'd0, 1, 12'd0, 12'd3990, 16'd1500);
    end
    send_event(etadp_pkg::ACT_END, 3'd0, 1, 12'hFFF, 12'hFFF, 16'hFFFF);
    send_event(etadp_pkg::ACT_CHARGED, 3'd1, 0, 12'hFFF, 12'd0, 16'hFFFF);
    send_event(etadp_pkg::ACT_END, 3'd1, 1, 12'd0, 12'd0, 16'd0);
    send_event(etadp_pkg::ACT_CHARGED, 3'd1, 1, 12'd0, 12'd0, 16'd5);
    send_event(etadp_pkg::ACT_END, 3'd1, 0, 12'd0, 12'd0, 16'd5);
  endtask

  task automatic test_config_sweep();
    set_config(8'd0, 12'd1, 16'd0, 13'd1, 8'd0);
    repeat (40) task_run();
    set_config(8'd255, 12'd1, 16'd0, 13'd4096, 8'd255);
    repeat (60) task_run();
    set_config(8'd255, 12'd4095, 16'd65535, 13'd4096, 8'd0);
    repeat (30) task_run();
    set_config(8'd200, 12'd3, 16'd500, 13'd2000, 8'd7);
    repeat (60) task_run();
  endtask

  task automatic test_backpressure();
    wait_idle();
    rx_hold = 400;
    for (int i = 0; i < 30; i++) send_noise();
  endtask

  task automatic test_random();
    for (int i = 0; i < 10; i++) begin
      set_config(8'($urandom), 12'($urandom_range(1, 4095)), 16'($urandom_range(0, 3000)),
                 13'($urandom_range(1, 4096)), 8'($urandom));
      gaps_on = (i != 3);
      repeat (50) begin
        if ($urandom_range(0, 5) == 0) send_noise();
        else task_run();
      end
    end
    gaps_on = 1;
  endtask

  initial begin
    cfg_max_index = etadp_pkg::RST_MAX_INDEX;
    cfg_code_step = etadp_pkg::RST_CODE_STEP;
    cfg_min_charge = etadp_pkg::RST_MIN_CHARGE;
    cfg_max_drop = etadp_pkg::RST_MAX_DROP;
    cfg_init_index = etadp_pkg::RST_INITIAL_INDEX;
    for (int t = 0; t < NTASK; t++) begin
      thr_q[t] = etadp_pkg::RST_INITIAL_INDEX;
      failed_q[t] = 0;
      ring_pos[t] = 0;
      for (int k = 0; k < RING; k++) ring_q[t][k] = '0;
    end
    prof_on = 0;
    ch_vcc = 0;
    ch_time = 0;
    ch_delta = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    wait_idle();
    if (expected_q.size() != 0) errors++;
    $display("Ran %0d events, checked %0d results: %0d drops stored, %0d mean updates.",
             n_items, n_results, n_kept, n_mean);
    $display("Covered register extremes, unused action, backpressure and idle gaps.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
